// ===== hw/rtl/bounded_array_insert_erase_core_macros.svh =====
// Assertion helpers used by the back end of the bounded array core.
`ifndef BOUNDED_ARRAY_INSERT_ERASE_CORE_MACROS_SVH
`define BOUNDED_ARRAY_INSERT_ERASE_CORE_MACROS_SVH

// Check cons in the same cycle that ante holds.
`define BAI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bai: same-cycle check failed");

// Check cons in the cycle after ante holds.
`define BAI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bai: next-cycle check failed");

`endif

// ===== hw/rtl/bai_pkg.sv =====
package bai_pkg;

  // Store geometry
  localparam int unsigned MAX_ENTRIES = 128;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Fixed field widths
  localparam int unsigned DATA_W = 64;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned CFG_W  = 8;

  // Common width for comparing positions, sizes and capacity
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CFG_W-1:0] CAP_RESET = 8'd100;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_READ   = 3'd0,
    MODE_WRITE  = 3'd1,
    MODE_PUSH   = 3'd2,
    MODE_POP    = 3'd3,
    MODE_INSERT = 3'd4,
    MODE_ERASE  = 3'd5,
    MODE_CLEAR  = 3'd6,
    MODE_RESIZE = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_SIZE  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_PUT,
    S_RESULT
  } back_state_e;

  typedef struct packed {
    mode_e              mode;
    logic [POS_W-1:0]   position;
    logic [DATA_W-1:0]  value_in;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic [DATA_W-1:0]  read_value;
    logic [POS_W-1:0]   size_now;
  } out_word_t;

  // Decoded command handed from front to back
  typedef struct packed {
    mode_e              op;
    logic               idx_chk;  // needs position < size
    logic [CMP_W-1:0]   pos;
    logic [DATA_W-1:0]  value;
  } cmd_t;

endpackage

// ===== hw/rtl/bounded_array_insert_erase_core.sv =====
// Channel | Direction | Handshake           | Word
// in      | input     | in_valid_i/stall_o  | bai_pkg::in_word_t (mode, position, value_in)
// out     | output    | out_valid_o/stall_i | bai_pkg::out_word_t (status, read_value, size_now)
// cfg     | input     | cfg_valid_i/ready_o | capacity_limit, 8 bits
//
// Back-end states per word: IDLE, RESULT for an error or a simple op; IDLE, READ, RESULT
// for a read; IDLE, SHIFT for each moved entry, PUT, RESULT for an insert that shifts;
// IDLE, SHIFT states, RESULT for an erase that shifts. The entry store, one read and one
// write port, moves one entry per cycle.
// A two-word command queue takes input while the back end works or the result waits.
// Reset clears the size, the valid bits (store reads as zero) and sets capacity 100.
// A stalled result holds in the output register; the back end waits on it.
module bounded_array_insert_erase_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bai_pkg::in_word_t          in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bai_pkg::out_word_t         out_word_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bai_pkg::CFG_W-1:0]  cfg_data_i
);

  logic [bai_pkg::CFG_W-1:0]  cap_cfg_q;
  logic                       cmd_valid, cmd_pop;
  bai_pkg::cmd_t              cmd;

  // Capacity register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_cfg_q <= bai_pkg::CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_cfg_q <= cfg_data_i;
    end
  end

  bai_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  bai_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_cfg_i   (cap_cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== hw/rtl/bai_front.sv =====
module bai_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bai_pkg::in_word_t  in_word_i,
  output logic               cmd_valid_o,
  output bai_pkg::cmd_t      cmd_o,
  input  logic               cmd_pop_i
);

  bai_pkg::cmd_t                    slot_q [bai_pkg::QUEUE_DEPTH];
  logic [bai_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [bai_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [bai_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  bai_pkg::cmd_t                    in_cmd;
  logic                             push;

  // Classify the incoming word
  always_comb begin
    in_cmd.op      = in_word_i.mode;
    in_cmd.idx_chk = (in_word_i.mode == bai_pkg::MODE_READ)  ||
                     (in_word_i.mode == bai_pkg::MODE_WRITE) ||
                     (in_word_i.mode == bai_pkg::MODE_ERASE);
    in_cmd.pos     = bai_pkg::CMP_W'(in_word_i.position);
    in_cmd.value   = in_word_i.value_in;
  end

  assign in_stall_o  = (cnt_q == bai_pkg::QCNT_W'(bai_pkg::QUEUE_DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == bai_pkg::QPTR_W'(bai_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + bai_pkg::QPTR_W'(1);
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == bai_pkg::QPTR_W'(bai_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + bai_pkg::QPTR_W'(1);
    end
    unique case ({push, cmd_pop_i})
      2'b10:   cnt_d = cnt_q + bai_pkg::QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - bai_pkg::QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the decoded word
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

// ===== hw/rtl/bai_back.sv =====
`include "bounded_array_insert_erase_core_macros.svh"

module bai_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [bai_pkg::CFG_W-1:0]  cap_cfg_i,
  input  logic                       cmd_valid_i,
  input  bai_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bai_pkg::out_word_t         out_word_o
);

  bai_pkg::back_state_e               state_q, state_d;
  bai_pkg::mode_e                     op_q;
  logic [bai_pkg::CMP_W-1:0]          pos_q;
  logic [bai_pkg::DATA_W-1:0]         val_q;
  logic [bai_pkg::IDX_W-1:0]          idx_q, idx_d;
  logic [bai_pkg::CNT_W-1:0]          size_q, size_d;
  bai_pkg::status_e                   res_status_q, res_status_d;
  logic [bai_pkg::DATA_W-1:0]         res_rd_q, res_rd_d;
  logic                               out_valid_q, out_valid_d;
  bai_pkg::out_word_t                 out_word_q, out_word_d;

  // Entry store, read data and per-entry valid bits (invalid reads as zero)
  logic [bai_pkg::DATA_W-1:0]         mem [bai_pkg::MAX_ENTRIES];
  logic [bai_pkg::DATA_W-1:0]         rdata_q;
  logic                               rvld_q;
  logic [bai_pkg::MAX_ENTRIES-1:0]    valid_q, valid_d;

  logic                               mem_we, mem_wvld, mem_re, drop_en, clear_low;
  logic [bai_pkg::IDX_W-1:0]          mem_waddr, mem_raddr, drop_idx;
  logic [bai_pkg::DATA_W-1:0]         mem_wdata;

  logic [bai_pkg::CMP_W-1:0]          size_w, cfg_w, max_w, cap_w;
  bai_pkg::status_e                   chk_status;
  logic                               out_free, ins_direct, ers_direct, ins_last, ers_last;

  // Effective capacity saturates at the store depth
  assign size_w = bai_pkg::CMP_W'(size_q);
  assign cfg_w  = bai_pkg::CMP_W'(cap_cfg_i);
  assign max_w  = bai_pkg::CMP_W'(bai_pkg::MAX_ENTRIES);
  assign cap_w  = (cfg_w > max_w) ? max_w : cfg_w;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign ins_direct = (cmd_i.pos == size_w);
  assign ers_direct = (cmd_i.pos + bai_pkg::CMP_W'(1) == size_w);
  assign ins_last   = (bai_pkg::CMP_W'(idx_q) - bai_pkg::CMP_W'(1) == pos_q);
  assign ers_last   = (bai_pkg::CMP_W'(idx_q) + bai_pkg::CMP_W'(2) == size_w);

  // Check the head command against size and capacity
  always_comb begin
    chk_status = bai_pkg::ST_OK;
    priority if (cmd_i.idx_chk) begin
      if (cmd_i.pos >= size_w) chk_status = bai_pkg::ST_BAD_INDEX;
    end else begin
      unique case (cmd_i.op)
        bai_pkg::MODE_PUSH: begin
          if (size_w >= cap_w) chk_status = bai_pkg::ST_FULL;
        end
        bai_pkg::MODE_POP: begin
          if (size_q == '0) chk_status = bai_pkg::ST_EMPTY;
        end
        bai_pkg::MODE_INSERT: begin
          if (cmd_i.pos > size_w)       chk_status = bai_pkg::ST_BAD_INDEX;
          else if (size_w >= cap_w)     chk_status = bai_pkg::ST_FULL;
        end
        bai_pkg::MODE_RESIZE: begin
          if (cmd_i.pos > cap_w) chk_status = bai_pkg::ST_BAD_SIZE;
        end
        default: chk_status = bai_pkg::ST_OK;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bai_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          if (chk_status != bai_pkg::ST_OK) begin
            state_d = bai_pkg::S_RESULT;
          end else begin
            unique case (cmd_i.op)
              bai_pkg::MODE_READ:   state_d = bai_pkg::S_READ;
              bai_pkg::MODE_INSERT: state_d = ins_direct ? bai_pkg::S_RESULT : bai_pkg::S_SHIFT;
              bai_pkg::MODE_ERASE:  state_d = ers_direct ? bai_pkg::S_RESULT : bai_pkg::S_SHIFT;
              default:              state_d = bai_pkg::S_RESULT;
            endcase
          end
        end
      end
      bai_pkg::S_READ: state_d = bai_pkg::S_RESULT;
      bai_pkg::S_SHIFT: begin
        if (op_q == bai_pkg::MODE_INSERT) begin
          if (ins_last) state_d = bai_pkg::S_PUT;
        end else if (ers_last) begin
          state_d = bai_pkg::S_RESULT;
        end
      end
      bai_pkg::S_PUT: state_d = bai_pkg::S_RESULT;
      bai_pkg::S_RESULT: begin
        if (out_free) state_d = bai_pkg::S_IDLE;
      end
      default: state_d = bai_pkg::S_IDLE;
    endcase
  end

  // Datapath controls per state
  always_comb begin
    cmd_pop_o    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = rdata_q;
    mem_wvld     = rvld_q;
    mem_re       = 1'b0;
    mem_raddr    = idx_q;
    drop_en      = 1'b0;
    drop_idx     = idx_q;
    clear_low    = 1'b0;
    size_d       = size_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_rd_d     = res_rd_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_word_d   = out_word_q;
    unique case (state_q)
      bai_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o    = 1'b1;
          res_status_d = chk_status;
          res_rd_d     = '0;
          if (chk_status == bai_pkg::ST_OK) begin
            unique case (cmd_i.op)
              bai_pkg::MODE_READ: begin
                mem_re    = 1'b1;
                mem_raddr = bai_pkg::IDX_W'(cmd_i.pos);
              end
              bai_pkg::MODE_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = bai_pkg::IDX_W'(cmd_i.pos);
                mem_wdata = cmd_i.value;
                mem_wvld  = 1'b1;
              end
              bai_pkg::MODE_PUSH: begin
                mem_we    = 1'b1;
                mem_waddr = bai_pkg::IDX_W'(size_q);
                mem_wdata = cmd_i.value;
                mem_wvld  = 1'b1;
                size_d    = size_q + bai_pkg::CNT_W'(1);
              end
              bai_pkg::MODE_POP: begin
                drop_en  = 1'b1;
                drop_idx = bai_pkg::IDX_W'(size_q - bai_pkg::CNT_W'(1));
                size_d   = size_q - bai_pkg::CNT_W'(1);
              end
              bai_pkg::MODE_INSERT: begin
                if (ins_direct) begin
                  mem_we    = 1'b1;
                  mem_waddr = bai_pkg::IDX_W'(cmd_i.pos);
                  mem_wdata = cmd_i.value;
                  mem_wvld  = 1'b1;
                  size_d    = size_q + bai_pkg::CNT_W'(1);
                end else begin
                  // start the upward shift from the top entry
                  mem_re    = 1'b1;
                  mem_raddr = bai_pkg::IDX_W'(size_q - bai_pkg::CNT_W'(1));
                  idx_d     = bai_pkg::IDX_W'(size_q);
                end
              end
              bai_pkg::MODE_ERASE: begin
                if (ers_direct) begin
                  drop_en  = 1'b1;
                  drop_idx = bai_pkg::IDX_W'(cmd_i.pos);
                  size_d   = size_q - bai_pkg::CNT_W'(1);
                end else begin
                  // start the downward shift just above the hole
                  mem_re    = 1'b1;
                  mem_raddr = bai_pkg::IDX_W'(cmd_i.pos + bai_pkg::CMP_W'(1));
                  idx_d     = bai_pkg::IDX_W'(cmd_i.pos);
                end
              end
              bai_pkg::MODE_CLEAR: begin
                clear_low = 1'b1;
                size_d    = '0;
              end
              bai_pkg::MODE_RESIZE: begin
                size_d = bai_pkg::CNT_W'(cmd_i.pos);
              end
              default: ;
            endcase
          end
        end
      end
      bai_pkg::S_READ: begin
        res_rd_d = rvld_q ? rdata_q : '0;
      end
      bai_pkg::S_SHIFT: begin
        // move one entry per cycle, prefetching the next source
        mem_we = 1'b1;
        if (op_q == bai_pkg::MODE_INSERT) begin
          if (!ins_last) begin
            mem_re    = 1'b1;
            mem_raddr = idx_q - bai_pkg::IDX_W'(2);
            idx_d     = idx_q - bai_pkg::IDX_W'(1);
          end
        end else if (ers_last) begin
          drop_en  = 1'b1;
          drop_idx = bai_pkg::IDX_W'(size_q - bai_pkg::CNT_W'(1));
          size_d   = size_q - bai_pkg::CNT_W'(1);
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + bai_pkg::IDX_W'(2);
          idx_d     = idx_q + bai_pkg::IDX_W'(1);
        end
      end
      bai_pkg::S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = bai_pkg::IDX_W'(pos_q);
        mem_wdata = val_q;
        mem_wvld  = 1'b1;
        size_d    = size_q + bai_pkg::CNT_W'(1);
      end
      bai_pkg::S_RESULT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_word_d.status     = res_status_q;
          out_word_d.read_value = res_rd_q;
          out_word_d.size_now   = bai_pkg::POS_W'(size_q);
        end
      end
      default: ;
    endcase
  end

  // Update valid bits: clear the live range, write, drop
  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < bai_pkg::MAX_ENTRIES; i++) begin
      if (clear_low && (bai_pkg::CNT_W'(i) < size_q)) valid_d[i] = 1'b0;
    end
    if (mem_we)  valid_d[mem_waddr] = mem_wvld;
    if (drop_en) valid_d[drop_idx]  = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bai_pkg::S_IDLE;
      size_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_rd_q     <= res_rd_d;
    out_word_q   <= out_word_d;
    if (cmd_pop_o) begin
      op_q  <= cmd_i.op;
      pos_q <= cmd_i.pos;
      val_q <= cmd_i.value;
    end
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
      rvld_q  <= valid_q[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `BAI_ASSERT_NOW(a_size_bound, clk_i, rst_ni, 1'b1, size_q <= bai_pkg::CNT_W'(bai_pkg::MAX_ENTRIES))
  `BAI_ASSERT_NOW(a_port_clash, clk_i, rst_ni, mem_we && mem_re, mem_waddr != mem_raddr)
  `BAI_ASSERT_NOW(a_pop_idle, clk_i, rst_ni, cmd_pop_o, (state_q == bai_pkg::S_IDLE) && cmd_valid_i)
  `BAI_ASSERT_NEXT(a_result_load, clk_i, rst_ni, (state_q == bai_pkg::S_RESULT) && out_free, out_valid_q && (state_q == bai_pkg::S_IDLE))

endmodule

// ===== verif/bai_array_checker.sv =====
module bai_array_checker
  import bai_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  in_word_t         in_word_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  out_word_t        out_word_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int               fail_count_o,
  output int               outstanding_o
);

  // Shadow copy of the array contents, its size and the capacity register
  logic [DATA_W-1:0] slot_mem [MAX_ENTRIES];
  int unsigned       fill_level;
  logic [CFG_W-1:0]  cap_limit;

  // Result words still owed by the block, oldest first
  out_word_t expected_results [$];
  int        mismatches = 0;

  assign fail_count_o = mismatches;

  // Saturate the register at the store depth
  function automatic int unsigned usable_capacity();
    return (cap_limit > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_limit);
  endfunction

  // Apply one input word to the shadow array and build its result word
  function automatic out_word_t array_op_result(in_word_t w);
    out_word_t   r;
    int unsigned pos;
    int unsigned cap;
    int unsigned i;
    pos          = int'(w.position);
    cap          = usable_capacity();
    r.status     = ST_OK;
    r.read_value = '0;
    case (w.mode)
      MODE_READ: begin
        if (pos >= fill_level) r.status = ST_BAD_INDEX;
        else r.read_value = slot_mem[pos];
      end
      MODE_WRITE: begin
        if (pos >= fill_level) r.status = ST_BAD_INDEX;
        else slot_mem[pos] = w.value_in;
      end
      MODE_PUSH: begin
        if (fill_level >= cap) begin
          r.status = ST_FULL;
        end else begin
          slot_mem[fill_level] = w.value_in;
          fill_level++;
        end
      end
      MODE_POP: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          fill_level--;
          slot_mem[fill_level] = '0;
        end
      end
      MODE_INSERT: begin
        // index check wins over the full check
        if (pos > fill_level) begin
          r.status = ST_BAD_INDEX;
        end else if (fill_level >= cap) begin
          r.status = ST_FULL;
        end else begin
          for (i = fill_level; i > pos; i--) slot_mem[i] = slot_mem[i-1];
          slot_mem[pos] = w.value_in;
          fill_level++;
        end
      end
      MODE_ERASE: begin
        if (pos >= fill_level) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (i = pos; i + 1 < fill_level; i++) slot_mem[i] = slot_mem[i+1];
          fill_level--;
          slot_mem[fill_level] = '0;
        end
      end
      MODE_CLEAR: begin
        for (i = 0; i < fill_level; i++) slot_mem[i] = '0;
        fill_level = 0;
      end
      MODE_RESIZE: begin
        // contents stay, so growing exposes whatever the slots still hold
        if (pos > cap) r.status = ST_BAD_SIZE;
        else fill_level = pos;
      end
      default: r.status = ST_OK;
    endcase
    r.size_now = fill_level[POS_W-1:0];
    return r;
  endfunction

  // Check result words, track register writes, predict from accepted input words
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    int        k;
    if (!rst_ni) begin
      for (k = 0; k < MAX_ENTRIES; k++) slot_mem[k] = '0;
      fill_level = 0;
      cap_limit  = CAP_RESET;
      expected_results.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: status %0d size %0d",
                 out_word_i.status, out_word_i.size_now);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_word_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_word_i.status);
            mismatches++;
          end
          if (out_word_i.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, out_word_i.read_value);
            mismatches++;
          end
          if (out_word_i.size_now !== want.size_now) begin
            $error("size_now: expected %0d, got %0d", want.size_now, out_word_i.size_now);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) cap_limit = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        expected_results.insert(expected_results.size(), array_op_result(in_word_i));
      end
      outstanding_o <= expected_results.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import bai_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_WORDS    = 160;
  localparam int PRESSURE_HOLD  = 400;
  localparam int DRAIN_CYCLES   = 150;

  logic             clk          = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_stall_o;
  in_word_t         in_word_i    = '0;
  logic             out_valid_o;
  logic             out_stall_i  = 1'b0;
  out_word_t        out_word_o;
  logic             cfg_valid_i  = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i   = '0;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  bit tx_eager    = 1'b0;
  bit rx_eager    = 1'b0;

  bounded_array_insert_erase_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  bai_array_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_word_i     (in_word_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_i    (out_word_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Abort when no channel has moved a word for too long
  always @(posedge clk) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drain result words with random stalls; hold off for a long stretch twice
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken == 300 || taken == 1200) hold = PRESSURE_HOLD;
      else if (rx_eager) hold = 0;
      else hold = $urandom_range(0, 15);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk); while (!out_valid_o);
      taken++;
    end
  end

  // Offer one input word, after a random gap unless tx_eager, and hold it until accepted
  task automatic send_word(input mode_e m, input logic [POS_W-1:0] p,
                           input logic [DATA_W-1:0] v);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{mode: m, position: p, value_in: v};
    do @(posedge clk); while (in_stall_o);
  endtask

  // Write the capacity register once every result word has come back
  task automatic set_capacity(input logic [CFG_W-1:0] c);
    in_valid_i <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Random operation; positions mostly land from zero to one past the capacity
  task automatic send_random_op(input int eff_cap);
    int                pick;
    mode_e             m;
    logic [POS_W-1:0]  p;
    logic [DATA_W-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 18) m = MODE_READ;
    else if (pick < 32) m = MODE_WRITE;
    else if (pick < 47) m = MODE_PUSH;
    else if (pick < 57) m = MODE_POP;
    else if (pick < 72) m = MODE_INSERT;
    else if (pick < 84) m = MODE_ERASE;
    else if (pick < 87) m = MODE_CLEAR;
    else m = MODE_RESIZE;
    pick = $urandom_range(0, 9);
    if (pick < 7) p = POS_W'($urandom_range(0, eff_cap + 1));
    else if (pick < 8) p = POS_W'($urandom_range(0, 3));
    else p = POS_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (pick == 0) v = '0;
    else if (pick == 1) v = '1;
    else v = {$urandom, $urandom};
    send_word(m, p, v);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] phase_caps [12];
    int               eff;
    phase_caps = '{8'd1, 8'd2, 8'd128, 8'd5, 8'd255, 8'd16,
                   8'd37, 8'd3, 8'd100, 8'd8, 8'd200, 8'd12};
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Empty array at reset capacity: every checked op must fail
    send_word(MODE_POP,    8'd0, '0);
    send_word(MODE_READ,   8'd0, '0);
    send_word(MODE_ERASE,  8'd0, '0);
    send_word(MODE_INSERT, 8'd1, '1);
    // Build a few entries with push and shifting insert
    send_word(MODE_INSERT, 8'd0, '1);
    send_word(MODE_PUSH,   8'd0, '0);
    send_word(MODE_INSERT, 8'd1, 64'h5555_5555_5555_5555);
    send_word(MODE_READ,   8'd1, '0);
    send_word(MODE_ERASE,  8'd0, '0);
    send_word(MODE_WRITE,  8'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    // Resize past the limit, up to it, then shrink and regrow over stale words
    send_word(MODE_RESIZE, 8'd101, '0);
    send_word(MODE_RESIZE, 8'd100, '0);
    send_word(MODE_RESIZE, 8'd1, '0);
    send_word(MODE_RESIZE, 8'd2, '0);
    send_word(MODE_READ,   8'd1, '0);
    send_word(MODE_CLEAR,  8'd0, '0);

    // Zero capacity: nothing fits
    set_capacity(8'd0);
    send_word(MODE_PUSH,   8'd0, '1);
    send_word(MODE_INSERT, 8'd0, '1);
    send_word(MODE_INSERT, 8'd1, '1);
    send_word(MODE_RESIZE, 8'd1, '0);
    send_word(MODE_RESIZE, 8'd0, '0);

    // Register above the store depth saturates; fill to the top and shift all
    set_capacity(8'd255);
    send_word(MODE_RESIZE, 8'd129, '0);
    send_word(MODE_RESIZE, 8'd128, '0);
    send_word(MODE_PUSH,   8'd0, '1);
    send_word(MODE_INSERT, 8'd128, '1);
    send_word(MODE_ERASE,  8'd127, '0);
    send_word(MODE_INSERT, 8'd0, 64'h8000_0000_0000_0001);

    // Capacity dropped below the size: entries stay, growth is refused
    set_capacity(8'd1);
    send_word(MODE_PUSH,   8'd0, '1);
    send_word(MODE_ERASE,  8'd0, '0);
    send_word(MODE_POP,    8'd0, '0);

    // Random phases, each under its own capacity and idling style
    foreach (phase_caps[p]) begin
      tx_eager = (p % 3 == 1);
      rx_eager = (p % 4 == 2);
      set_capacity(phase_caps[p]);
      eff = (phase_caps[p] > MAX_ENTRIES) ? MAX_ENTRIES : int'(phase_caps[p]);
      repeat (PHASE_WORDS) send_random_op(eff);
    end

    // Wait for the last result words, then a little longer for strays
    in_valid_i <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
